// File: design/assert_macros.svh
// assert_macros.svh: assertion shorthands for the step sequencer RTL.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/mss_pkg.sv
// mss_pkg: codes, word layouts and controller/datapath structs of the step sequencer.
// No dependencies; used by motion_step_sequencer, mss_ctrl and mss_dpath.
`default_nettype none

package mss_pkg;

	localparam logic [2:0] CMD_ADD_TIMED = 3'd0;
	localparam logic [2:0] CMD_ADD_ANGLE = 3'd1;
	localparam logic [2:0] CMD_RUN       = 3'd2;
	localparam logic [2:0] CMD_STOP      = 3'd3;
	localparam logic [2:0] CMD_CLEAR     = 3'd4;
	localparam logic [2:0] CMD_TICK      = 3'd5;

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_START  = 3'd1;
	localparam logic [2:0] ACT_STOP   = 3'd2;
	localparam logic [2:0] ACT_ANGLE  = 3'd3;
	localparam logic [2:0] ACT_CANCEL = 3'd4;

	localparam logic [2:0] JOINT_GRIPPER  = 3'd0;
	localparam logic [2:0] JOINT_WRIST    = 3'd1;
	localparam logic [2:0] JOINT_ELBOW    = 3'd2;
	localparam logic [2:0] JOINT_SHOULDER = 3'd3;
	localparam logic [2:0] JOINT_BASE     = 3'd4;

	localparam logic [2:0] DIR_OPEN  = 3'd0;
	localparam logic [2:0] DIR_CLOSE = 3'd1;
	localparam logic [2:0] DIR_UP    = 3'd2;
	localparam logic [2:0] DIR_DOWN  = 3'd3;
	localparam logic [2:0] DIR_LEFT  = 3'd4;
	localparam logic [2:0] DIR_RIGHT = 3'd5;

	localparam logic [1:0] CFG_MIN_TARGET = 2'd0;
	localparam logic [1:0] CFG_MAX_TARGET = 2'd1;

	localparam logic [11:0] MIN_TARGET_RST = 12'd1;
	localparam logic [11:0] MAX_TARGET_RST = 12'd3600;
	localparam logic [7:0]  SPEED_MAX      = 8'd100;

	typedef enum logic [1:0] {
		RS_IDLE      = 2'd0,
		RS_RUNNING   = 2'd1,
		RS_COMPLETED = 2'd2,
		RS_STOPPED   = 2'd3
	} run_state_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_EXEC,
		F_START,
		F_EMIT
	} fsm_t;

	typedef struct packed {
		logic [3:0]  pad;
		logic        shoulder_down_ok;
		logic        shoulder_up_ok;
		logic        angle_reached;
		logic        angle_busy;
		logic        motion_blocked;
		logic        armed;
		logic [31:0] now_ms;
		logic [31:0] step_amount;
		logic [7:0]  speed;
		logic [2:0]  direction;
		logic [2:0]  joint;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  pad;
		logic [11:0] action_target;
		logic [6:0]  action_speed;
		logic [2:0]  action_dir;
		logic [2:0]  action_joint;
		logic [4:0]  step_count;
		logic [4:0]  step_index;
		logic [1:0]  seq_state;
		logic        accepted;
	} out_word_t;

	typedef struct packed {
		logic        is_angle;
		logic [2:0]  joint;
		logic [2:0]  dir;
		logic [6:0]  speed;
		logic [31:0] amount;
	} step_t;

	typedef struct packed {
		logic       cap;
		logic       add;
		logic       rs_we;
		run_state_t rs_val;
		logic       q_clr;
		logic       cur_zero;
		logic       cur_inc;
		logic       t_load;
		logic       acc_set;
		logic       act_push;
		logic [2:0] act_kind;
		logic       out_load;
		logic       out_sel;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       armed;
		logic       blocked;
		logic       busy;
		logic       reached;
		run_state_t rs;
		logic       cur_lt_q;
		logic       next_lt_q;
		logic       q_nonzero;
		logic       add_ok;
		logic       is_angle;
		logic       joint_sh;
		logic       sh_allowed;
		logic       pair_ok;
		logic       elapsed_done;
		logic [1:0] act_cnt;
		logic       out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: design/motion_step_sequencer.sv
// motion_step_sequencer: top level of the joint step sequencer.
// Depends on mss_pkg, mss_ctrl, mss_dpath and mss_ram.
//
// Input words arrive on s_axis: tuser carries the command, tdata the step
// fields, the tick time and the status flags of the arm. Every input word
// gives one or two result words on m_axis; tlast marks the final one, tuser
// carries the action code. Configuration writes (cfg_we, cfg_index,
// cfg_data) set the angle target limits; the user must write them only while
// the block idles, which the block itself does not enforce. One word is
// handled at a time: an accepted word passes the execute state, the start
// state when a step is started, and the emit state once per result before
// the next word is accepted. The step queue is a RAM with registered read;
// a step starts on its read data. A single output register holds results;
// a stalled receiver holds the word there, and the sequencer waits at the
// next result until it is taken. Reset clears the queue count, cursor,
// run state and output valid, and restores the default target limits.
`default_nettype none

module motion_step_sequencer #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// joint, direction, speed, step_amount, now_ms, armed, motion_blocked,
	// angle_busy, angle_reached, shoulder_up_ok, shoulder_down_ok
	input  wire logic [87:0] s_axis_tdata,
	// command
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// accepted, seq_state, step_index, step_count, action_joint, action_dir,
	// action_speed, action_target
	output logic [39:0]      m_axis_tdata,
	// action
	output logic [2:0]       m_axis_tuser,
	output logic             m_axis_tlast
);

	mss_pkg::dp_cmd_t  ctl;
	mss_pkg::dp_stat_t stat;

	mss_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.ctl           (ctl)
	);

	mss_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.ctl           (ctl),
		.stat          (stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: design/mss_ram.sv
// mss_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mss_ram #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: design/mss_dpath.sv
// mss_dpath: registers, step queue RAM, checks and result register of the sequencer.
// Depends on mss_pkg, mss_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mss_dpath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [11:0]       cfg_data,
	input  wire logic [87:0]       s_axis_tdata,
	input  wire logic [2:0]        s_axis_tuser,
	input  wire mss_pkg::dp_cmd_t  ctl,
	output mss_pkg::dp_stat_t      stat,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [39:0]            m_axis_tdata,
	output logic [2:0]             m_axis_tuser,
	output logic                   m_axis_tlast
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	mss_pkg::in_word_t   in_w;
	mss_pkg::out_word_t  out_w;
	mss_pkg::step_t      step, new_step;
	mss_pkg::run_state_t rs_q;

	logic [11:0] min_q, max_q;
	logic [2:0]  cmd_q, joint_q, dir_q;
	logic [7:0]  speed_q;
	logic [31:0] amount_q, now_q, started_q, elapsed;
	logic        armed_q, blocked_q, busy_q, reached_q, up_ok_q, down_ok_q;
	logic        acc_q;
	logic [CW-1:0] cursor_q, queued_q, cursor_d, eff_q;
	logic [1:0]  act_cnt_q;
	logic [2:0]  slot_kind_q [2];
	logic [2:0]  slot_joint_q [2];
	logic [2:0]  slot_dir_q [2];
	logic [6:0]  slot_speed_q [2];
	logic [11:0] slot_tgt_q [2];
	logic [2:0]  p_joint, p_dir;
	logic [6:0]  p_speed;
	logic [11:0] p_tgt;
	logic        done, speed_ok, amt_ok, add_ok, ram_we, has, out_free, m_valid_q;
	logic [45:0] rd_data;

	assign in_w = mss_pkg::in_word_t'(s_axis_tdata);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= mss_pkg::MIN_TARGET_RST;
			max_q <= mss_pkg::MAX_TARGET_RST;
		end else if (cfg_we) begin
			if (cfg_index == mss_pkg::CFG_MIN_TARGET) begin
				min_q <= cfg_data;
			end else if (cfg_index == mss_pkg::CFG_MAX_TARGET) begin
				max_q <= cfg_data;
			end
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q     <= s_axis_tuser;
			joint_q   <= in_w.joint;
			dir_q     <= in_w.direction;
			speed_q   <= in_w.speed;
			amount_q  <= in_w.step_amount;
			now_q     <= in_w.now_ms;
			armed_q   <= in_w.armed;
			blocked_q <= in_w.motion_blocked;
			busy_q    <= in_w.angle_busy;
			reached_q <= in_w.angle_reached;
			up_ok_q   <= in_w.shoulder_up_ok;
			down_ok_q <= in_w.shoulder_down_ok;
		end
	end

	// add checks
	assign done     = (rs_q == mss_pkg::RS_COMPLETED) || (rs_q == mss_pkg::RS_STOPPED);
	assign eff_q    = done ? '0 : queued_q;
	assign speed_ok = (speed_q != 8'd0) && (speed_q <= mss_pkg::SPEED_MAX);
	assign amt_ok   = (cmd_q == mss_pkg::CMD_ADD_TIMED) ? (amount_q != 32'd0) :
		(((dir_q == mss_pkg::DIR_LEFT) || (dir_q == mss_pkg::DIR_RIGHT)) &&
		(amount_q >= {20'd0, min_q}) && (amount_q <= {20'd0, max_q}));
	assign add_ok   = (eff_q < CW'(QUEUE_DEPTH)) && speed_ok && amt_ok;
	assign ram_we   = ctl.add && add_ok;

	always_comb begin
		new_step.is_angle = (cmd_q == mss_pkg::CMD_ADD_ANGLE) && (amount_q != 32'd0);
		new_step.joint    = (cmd_q == mss_pkg::CMD_ADD_ANGLE) ? mss_pkg::JOINT_BASE : joint_q;
		new_step.dir      = dir_q;
		new_step.speed    = speed_q[6:0];
		new_step.amount   = amount_q;
	end

	// cursor, next value also addresses the queue
	always_comb begin
		if (ctl.q_clr || ctl.cur_zero || (ctl.add && done)) begin
			cursor_d = '0;
		end else if (ctl.cur_inc) begin
			cursor_d = cursor_q + CW'(1);
		end else begin
			cursor_d = cursor_q;
		end
	end

	mss_ram #(
		.WIDTH ($bits(mss_pkg::step_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (eff_q[AW-1:0]),
		.wdata (new_step),
		.raddr (cursor_d[AW-1:0]),
		.rdata (rd_data)
	);

	assign step    = mss_pkg::step_t'(rd_data);
	assign elapsed = now_q - started_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q      <= mss_pkg::RS_IDLE;
			cursor_q  <= '0;
			queued_q  <= '0;
			started_q <= '0;
			acc_q     <= 1'b0;
			act_cnt_q <= 2'd0;
		end else begin
			cursor_q <= cursor_d;
			if (ctl.cap) begin
				acc_q     <= 1'b0;
				act_cnt_q <= 2'd0;
			end
			if (ctl.add) begin
				if (done) begin
					rs_q     <= mss_pkg::RS_IDLE;
					queued_q <= '0;
				end
				if (add_ok) begin
					queued_q <= eff_q + CW'(1);
					acc_q    <= 1'b1;
				end
			end
			if (ctl.rs_we) begin
				rs_q <= ctl.rs_val;
			end
			if (ctl.q_clr) begin
				queued_q <= '0;
			end
			if (ctl.t_load) begin
				started_q <= now_q;
			end
			if (ctl.acc_set) begin
				acc_q <= 1'b1;
			end
			if (ctl.act_push) begin
				act_cnt_q <= act_cnt_q + 2'd1;
			end
		end
	end

	// action fields by kind
	always_comb begin
		p_joint = step.joint;
		p_dir   = 3'd0;
		p_speed = 7'd0;
		p_tgt   = 12'd0;
		unique case (ctl.act_kind)
			mss_pkg::ACT_START: begin
				p_dir   = step.dir;
				p_speed = step.speed;
			end
			mss_pkg::ACT_ANGLE: begin
				p_joint = mss_pkg::JOINT_BASE;
				p_dir   = step.dir;
				p_speed = step.speed;
				p_tgt   = step.amount[11:0];
			end
			mss_pkg::ACT_CANCEL: begin
				p_joint = mss_pkg::JOINT_BASE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.act_push) begin
			slot_kind_q[act_cnt_q[0]]  <= ctl.act_kind;
			slot_joint_q[act_cnt_q[0]] <= p_joint;
			slot_dir_q[act_cnt_q[0]]   <= p_dir;
			slot_speed_q[act_cnt_q[0]] <= p_speed;
			slot_tgt_q[act_cnt_q[0]]   <= p_tgt;
		end
	end

	// result register
	assign out_free = !m_valid_q || m_axis_tready;
	assign has      = {1'b0, ctl.out_sel} < act_cnt_q;

	always_comb begin
		out_w.pad           = 2'd0;
		out_w.accepted      = acc_q;
		out_w.seq_state     = rs_q;
		out_w.step_index    = 5'(cursor_q);
		out_w.step_count    = 5'(queued_q);
		out_w.action_joint  = has ? slot_joint_q[ctl.out_sel] : 3'd0;
		out_w.action_dir    = has ? slot_dir_q[ctl.out_sel] : 3'd0;
		out_w.action_speed  = has ? slot_speed_q[ctl.out_sel] : 7'd0;
		out_w.action_target = has ? slot_tgt_q[ctl.out_sel] : 12'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			m_axis_tdata <= out_w;
			m_axis_tuser <= has ? slot_kind_q[ctl.out_sel] : mss_pkg::ACT_NONE;
			m_axis_tlast <= ctl.out_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;

	// status to the controller
	always_comb begin
		stat.cmd          = cmd_q;
		stat.armed        = armed_q;
		stat.blocked      = blocked_q;
		stat.busy         = busy_q;
		stat.reached      = reached_q;
		stat.rs           = rs_q;
		stat.cur_lt_q     = cursor_q < queued_q;
		stat.next_lt_q    = ({1'b0, cursor_q} + (CW+1)'(1)) < {1'b0, queued_q};
		stat.q_nonzero    = queued_q != '0;
		stat.add_ok       = add_ok;
		stat.is_angle     = step.is_angle;
		stat.joint_sh     = step.joint == mss_pkg::JOINT_SHOULDER;
		stat.sh_allowed   = (step.dir == mss_pkg::DIR_UP) ? up_ok_q : down_ok_q;
		stat.elapsed_done = elapsed >= step.amount;
		stat.act_cnt      = act_cnt_q;
		stat.out_free     = out_free;
		unique case (step.joint)
			mss_pkg::JOINT_GRIPPER:
				stat.pair_ok = (step.dir == mss_pkg::DIR_OPEN) ||
					(step.dir == mss_pkg::DIR_CLOSE);
			mss_pkg::JOINT_WRIST, mss_pkg::JOINT_ELBOW:
				stat.pair_ok = (step.dir == mss_pkg::DIR_UP) || (step.dir == mss_pkg::DIR_DOWN);
			mss_pkg::JOINT_SHOULDER:
				stat.pair_ok = ((step.dir == mss_pkg::DIR_UP) && up_ok_q) ||
					((step.dir == mss_pkg::DIR_DOWN) && down_ok_q);
			mss_pkg::JOINT_BASE:
				stat.pair_ok = (step.dir == mss_pkg::DIR_LEFT) ||
					(step.dir == mss_pkg::DIR_RIGHT);
			default:
				stat.pair_ok = 1'b0;
		endcase
	end

	`MSS_ASSERT_IMP(a_cursor_le_count, 1'b1, cursor_q <= queued_q, "cursor beyond queue count")
	`MSS_ASSERT_IMP(a_count_le_depth, 1'b1, queued_q <= CW'(QUEUE_DEPTH), "queue overfilled")
	`MSS_ASSERT_NXT(a_push_counts, ram_we, queued_q != '0, "accepted add left queue empty")

endmodule

`default_nettype wire

// File: design/mss_ctrl.sv
// mss_ctrl: state machine that sequences one input word through execute, start and emit.
// Depends on mss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mss_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire mss_pkg::dp_stat_t stat,
	output mss_pkg::dp_cmd_t       ctl
);

	mss_pkg::fsm_t state_q, state_d;
	logic          idx_q, idx_d;
	logic          last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mss_pkg::F_IDLE;
			idx_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign last = idx_q || (stat.act_cnt < 2'd2);

	always_comb begin
		ctl           = '0;
		state_d       = state_q;
		idx_d         = idx_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			mss_pkg::F_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					ctl.cap = 1'b1;
					state_d = mss_pkg::F_EXEC;
				end
			end
			mss_pkg::F_EXEC: begin
				state_d = mss_pkg::F_EMIT;
				unique case (stat.cmd)
					mss_pkg::CMD_ADD_TIMED, mss_pkg::CMD_ADD_ANGLE: begin
						ctl.add = 1'b1;
					end
					mss_pkg::CMD_RUN: begin
						if (stat.q_nonzero && (stat.rs != mss_pkg::RS_RUNNING) &&
							stat.armed && !stat.blocked) begin
							ctl.cur_zero = 1'b1;
							ctl.rs_we    = 1'b1;
							ctl.rs_val   = mss_pkg::RS_RUNNING;
							ctl.t_load   = 1'b1;
							state_d      = mss_pkg::F_START;
						end
					end
					mss_pkg::CMD_STOP, mss_pkg::CMD_CLEAR: begin
						if (stat.rs == mss_pkg::RS_RUNNING) begin
							ctl.act_push = stat.cur_lt_q;
							ctl.act_kind = stat.is_angle ? mss_pkg::ACT_CANCEL : mss_pkg::ACT_STOP;
							ctl.rs_we    = 1'b1;
							ctl.rs_val   = mss_pkg::RS_STOPPED;
						end
						if (stat.cmd == mss_pkg::CMD_CLEAR) begin
							ctl.rs_we  = 1'b1;
							ctl.rs_val = mss_pkg::RS_IDLE;
							ctl.q_clr  = 1'b1;
						end
					end
					mss_pkg::CMD_TICK: begin
						if (stat.rs == mss_pkg::RS_RUNNING) begin
							priority if (!stat.armed) begin
								ctl.act_push = stat.cur_lt_q;
								ctl.act_kind = stat.is_angle ? mss_pkg::ACT_CANCEL :
									mss_pkg::ACT_STOP;
								ctl.rs_we    = 1'b1;
								ctl.rs_val   = mss_pkg::RS_STOPPED;
							end else if (!stat.cur_lt_q) begin
								ctl.rs_we  = 1'b1;
								ctl.rs_val = mss_pkg::RS_COMPLETED;
							end else if (stat.is_angle) begin
								if (!stat.busy) begin
									if (stat.reached) begin
										ctl.cur_inc = 1'b1;
										if (stat.next_lt_q) begin
											state_d = mss_pkg::F_START;
										end else begin
											ctl.rs_we  = 1'b1;
											ctl.rs_val = mss_pkg::RS_COMPLETED;
										end
									end else begin
										ctl.rs_we  = 1'b1;
										ctl.rs_val = mss_pkg::RS_STOPPED;
									end
								end
							end else if (stat.joint_sh && !stat.sh_allowed) begin
								ctl.act_push = 1'b1;
								ctl.act_kind = mss_pkg::ACT_STOP;
								ctl.rs_we    = 1'b1;
								ctl.rs_val   = mss_pkg::RS_STOPPED;
							end else if (stat.elapsed_done) begin
								ctl.act_push = 1'b1;
								ctl.act_kind = mss_pkg::ACT_STOP;
								ctl.cur_inc  = 1'b1;
								if (stat.next_lt_q) begin
									state_d = mss_pkg::F_START;
								end else begin
									ctl.rs_we  = 1'b1;
									ctl.rs_val = mss_pkg::RS_COMPLETED;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
			mss_pkg::F_START: begin
				state_d = mss_pkg::F_EMIT;
				priority if (!stat.cur_lt_q) begin
					ctl.rs_we  = 1'b1;
					ctl.rs_val = mss_pkg::RS_COMPLETED;
				end else if (stat.is_angle || stat.pair_ok) begin
					ctl.act_push = 1'b1;
					ctl.act_kind = stat.is_angle ? mss_pkg::ACT_ANGLE : mss_pkg::ACT_START;
					ctl.t_load   = 1'b1;
					ctl.acc_set  = stat.cmd == mss_pkg::CMD_RUN;
				end else begin
					ctl.rs_we  = 1'b1;
					ctl.rs_val = mss_pkg::RS_STOPPED;
				end
			end
			mss_pkg::F_EMIT: begin
				ctl.out_sel  = idx_q;
				ctl.out_last = last;
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					if (last) begin
						idx_d   = 1'b0;
						state_d = mss_pkg::F_IDLE;
					end else begin
						idx_d = 1'b1;
					end
				end
			end
			default: begin
				state_d = mss_pkg::F_IDLE;
			end
		endcase
	end

	`MSS_ASSERT_IMP(a_load_when_free, ctl.out_load, stat.out_free, "result overwrites a held word")
	`MSS_ASSERT_IMP(a_start_running, state_q == mss_pkg::F_START,
		stat.rs == mss_pkg::RS_RUNNING, "step start outside a running sequence")
	`MSS_ASSERT_IMP(a_two_actions, stat.act_cnt == 2'd2, !ctl.act_push,
		"third action pushed for one word")

endmodule

`default_nettype wire

// File: tb/tb_motion_step_sequencer.sv
// Self-checking testbench for motion_step_sequencer: drives command words on the
// input stream, predicts every result word and checks the output stream field by field.
// Depends on mss_pkg and the motion_step_sequencer RTL.
module tb_motion_step_sequencer;
	timeunit 1ns;
	timeprecision 1ps;
	import mss_pkg::*;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_SETS = 5;
	localparam logic [2:0] CMD_UNUSED = 3'd6;
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;
	// status flag bits, lowest first: armed, blocked, busy, reached, up ok, down ok
	localparam logic [5:0] FL_ARMED = 6'b000001;
	localparam logic [5:0] FL_BLOCKED = 6'b000010;
	localparam logic [5:0] FL_BUSY = 6'b000100;
	localparam logic [5:0] FL_REACHED = 6'b001000;
	localparam logic [5:0] FL_UP = 6'b010000;
	localparam logic [5:0] FL_DOWN = 6'b100000;
	localparam logic [5:0] FL_NORMAL = FL_ARMED | FL_UP | FL_DOWN;

	typedef struct {
		logic [2:0] cmd;
		in_word_t   word;
	} cmd_word_s;

	typedef struct {
		logic        is_angle;
		logic [2:0]  joint;
		logic [2:0]  dir;
		logic [7:0]  speed;
		logic [31:0] amount;
	} seq_step_s;

	typedef struct {
		logic [2:0]  kind;
		logic [2:0]  joint;
		logic [2:0]  dir;
		logic [6:0]  speed;
		logic [11:0] target;
	} motor_act_s;

	typedef struct {
		logic        accepted;
		logic [1:0]  state;
		logic [4:0]  idx;
		logic [4:0]  cnt;
		motor_act_s  act;
		logic        last;
	} seq_result_s;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	cmd_word_s   cmd_backlog[$];
	seq_result_s owed_results[$];
	motor_act_s  step_actions[$];

	// predictor state
	run_state_t  rs = RS_IDLE;
	logic [4:0]  cur = '0;
	logic [4:0]  qd = '0;
	logic [31:0] t_start = '0;
	seq_step_s   step_q[DEPTH];
	logic [11:0] lim_min = MIN_TARGET_RST;
	logic [11:0] lim_max = MAX_TARGET_RST;
	logic        up_ok, down_ok;

	logic [31:0] ms_now = 32'hFFFF_FFFE;
	int          item_total = 0;
	int          gap_pct = 35;
	int          stall_pct = 35;
	bit          hold_arm = 1'b0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          mismatches = 0;
	int          words_in = 0;
	int          results_seen = 0;
	int          completions = 0;
	int          cycles = 0;

	motion_step_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10ns clk = ~clk;

	function void push_action(logic [2:0] kind, logic [2:0] joint, logic [2:0] dir,
		logic [6:0] speed, logic [11:0] target);
		if (step_actions.size() < 2)
			step_actions.push_back('{kind, joint, dir, speed, target});
	endfunction

	function bit launch_step(logic [31:0] now);
		seq_step_s s;
		bit ok;
		if (cur >= qd || cur >= DEPTH) begin
			rs = RS_COMPLETED;
			return 1'b0;
		end
		s = step_q[cur];
		if (s.is_angle) begin
			push_action(ACT_ANGLE, JOINT_BASE, s.dir, s.speed[6:0], s.amount[11:0]);
		end else begin
			case (s.joint)
				JOINT_GRIPPER: ok = s.dir == DIR_OPEN || s.dir == DIR_CLOSE;
				JOINT_WRIST, JOINT_ELBOW: ok = s.dir == DIR_UP || s.dir == DIR_DOWN;
				JOINT_SHOULDER: ok = (s.dir == DIR_UP) ? up_ok : (s.dir == DIR_DOWN) ? down_ok : 1'b0;
				JOINT_BASE: ok = s.dir == DIR_LEFT || s.dir == DIR_RIGHT;
				default: ok = 1'b0;
			endcase
			if (!ok) begin
				rs = RS_STOPPED;
				return 1'b0;
			end
			push_action(ACT_START, s.joint, s.dir, s.speed[6:0], '0);
		end
		t_start = now;
		return 1'b1;
	endfunction

	function void next_step(logic [31:0] now);
		cur++;
		if (cur >= qd)
			rs = RS_COMPLETED;
		else
			void'(launch_step(now));
	endfunction

	function void halt_run();
		if (rs != RS_RUNNING)
			return;
		if (cur < qd && cur < DEPTH) begin
			if (step_q[cur].is_angle)
				push_action(ACT_CANCEL, JOINT_BASE, '0, '0, '0);
			else
				push_action(ACT_STOP, step_q[cur].joint, '0, '0, '0);
		end
		rs = RS_STOPPED;
	endfunction

	function void wipe_queue();
		halt_run();
		qd = '0;
		cur = '0;
		rs = RS_IDLE;
	endfunction

	// work out the result words of one accepted command word
	function void sequencer_update(logic [2:0] cmd, in_word_t w);
		bit ok;
		bit acc;
		seq_step_s s;
		logic [31:0] elapsed;
		run_state_t rs_prior;
		int n;
		acc = 1'b0;
		rs_prior = rs;
		up_ok = w.shoulder_up_ok;
		down_ok = w.shoulder_down_ok;
		step_actions.delete();
		case (cmd)
			CMD_ADD_TIMED, CMD_ADD_ANGLE: begin
				if (rs == RS_COMPLETED || rs == RS_STOPPED)
					wipe_queue();
				ok = qd < DEPTH && w.speed >= 8'd1 && w.speed <= SPEED_MAX;
				if (cmd == CMD_ADD_TIMED)
					ok = ok && w.step_amount != 0;
				else
					ok = ok && (w.direction == DIR_LEFT || w.direction == DIR_RIGHT) &&
						w.step_amount >= lim_min && w.step_amount <= lim_max;
				if (ok) begin
					step_q[qd] = '{cmd == CMD_ADD_ANGLE && w.step_amount != 0,
						(cmd == CMD_ADD_ANGLE) ? JOINT_BASE : w.joint,
						w.direction, w.speed, w.step_amount};
					qd++;
					acc = 1'b1;
				end
			end
			CMD_RUN: begin
				if (qd != 0 && rs != RS_RUNNING && w.armed && !w.motion_blocked) begin
					cur = '0;
					rs = RS_RUNNING;
					t_start = w.now_ms;
					if (launch_step(w.now_ms))
						acc = 1'b1;
					else
						rs = RS_STOPPED;
				end
			end
			CMD_STOP: halt_run();
			CMD_CLEAR: wipe_queue();
			CMD_TICK: begin
				if (rs == RS_RUNNING) begin
					if (!w.armed) begin
						halt_run();
					end else if (cur >= qd || cur >= DEPTH) begin
						rs = RS_COMPLETED;
					end else begin
						s = step_q[cur];
						elapsed = w.now_ms - t_start;
						if (s.is_angle) begin
							if (!w.angle_busy) begin
								if (w.angle_reached)
									next_step(w.now_ms);
								else
									rs = RS_STOPPED;
							end
						end else if (s.joint == JOINT_SHOULDER &&
							!((s.dir == DIR_UP) ? up_ok : down_ok)) begin
							push_action(ACT_STOP, s.joint, '0, '0, '0);
							rs = RS_STOPPED;
						end else if (elapsed >= s.amount) begin
							push_action(ACT_STOP, s.joint, '0, '0, '0);
							next_step(w.now_ms);
						end
					end
				end
			end
			default: ;
		endcase
		if (rs == RS_COMPLETED && rs_prior != RS_COMPLETED)
			completions++;
		n = (step_actions.size() > 0) ? step_actions.size() : 1;
		for (int k = 0; k < n; k++) begin
			owed_results.push_back('{acc, rs, cur, qd,
				(k < step_actions.size()) ? step_actions[k] : '{ACT_NONE, '0, '0, '0, '0},
				k == n - 1});
		end
	endfunction

	function void put(logic [2:0] cmd, logic [2:0] joint, logic [2:0] dir, logic [7:0] speed,
		logic [31:0] amount, logic [31:0] now, logic [5:0] flags);
		cmd_backlog.push_back('{cmd, {4'd0, flags, now, amount, speed, dir, joint}});
		if (cmd <= CMD_TICK)
			item_total++;
	endfunction

	function void fill_random(int n);
		int goal, nsteps, k, r;
		logic [2:0] j, d, c;
		logic [31:0] amt;
		logic [5:0] fl;
		goal = item_total + n;
		while (item_total < goal) begin
			if ($urandom_range(0, 99) < 82) begin
				if ($urandom_range(0, 1))
					put(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, ms_now, $urandom);
				nsteps = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 4);
				for (k = 0; k < nsteps; k++) begin
					r = $urandom_range(0, 99);
					if (r < 8) begin
						case ($urandom_range(0, 2))
							0: amt = '0;
							1: amt = $urandom;
							default: amt = {20'd0, lim_max} + 32'd1;
						endcase
						put($urandom_range(0, 1) ? CMD_ADD_ANGLE : CMD_ADD_TIMED, $urandom,
							$urandom, $urandom, amt, ms_now, FL_NORMAL);
					end else if (r < 65) begin
						j = $urandom_range(0, 4);
						case (j)
							JOINT_GRIPPER: d = $urandom_range(0, 1) ? DIR_CLOSE : DIR_OPEN;
							JOINT_BASE: d = $urandom_range(0, 1) ? DIR_RIGHT : DIR_LEFT;
							default: d = $urandom_range(0, 1) ? DIR_DOWN : DIR_UP;
						endcase
						amt = ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(1, 30);
						put(CMD_ADD_TIMED, j, d, $urandom_range(1, 100), amt, ms_now, FL_NORMAL);
					end else begin
						if (lim_min > lim_max) begin
							amt = $urandom_range(1, 3600);
						end else begin
							case ($urandom_range(0, 9))
								0: amt = lim_min;
								1: amt = lim_max;
								default: amt = $urandom_range(lim_min, lim_max);
							endcase
						end
						put(CMD_ADD_ANGLE, JOINT_BASE, $urandom_range(0, 1) ? DIR_RIGHT : DIR_LEFT,
							$urandom_range(1, 100), amt, ms_now, FL_NORMAL);
					end
				end
				fl = {($urandom_range(0, 99) < 95), ($urandom_range(0, 99) < 95),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					($urandom_range(0, 99) < 8), ($urandom_range(0, 99) < 92)};
				put(CMD_RUN, $urandom, $urandom, $urandom, $urandom, ms_now, fl);
				for (k = 0; k < nsteps * 3 + 2; k++) begin
					ms_now += ($urandom_range(0, 39) == 0) ? $urandom : $urandom_range(0, 40);
					fl = {($urandom_range(0, 99) < 95), ($urandom_range(0, 99) < 95),
						($urandom_range(0, 99) < 85), ($urandom_range(0, 99) < 40),
						1'($urandom_range(0, 1)), ($urandom_range(0, 99) < 97)};
					r = $urandom_range(0, 99);
					if (r < 3)
						c = CMD_STOP;
					else if (r < 6)
						c = CMD_CLEAR;
					else if (r < 8)
						c = CMD_RUN;
					else
						c = CMD_TICK;
					put(c, $urandom, $urandom, $urandom, $urandom, ms_now, fl);
				end
			end else begin
				nsteps = $urandom_range(1, 6);
				for (k = 0; k < nsteps; k++)
					put($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
		end
	endfunction

	function void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || s_axis_tvalid || owed_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [11:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIN_TARGET)
			lim_min = val;
		else if (idx == CFG_MAX_TARGET)
			lim_max = val;
		@(negedge clk);
	endtask

	// sender
	always @(posedge clk) begin : sender
		cmd_word_s nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				sequencer_update(s_axis_tuser, in_word_t'(s_axis_tdata));
				words_in++;
			end
			if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				nxt = cmd_backlog.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= nxt.cmd;
				s_axis_tdata <= nxt.word;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin : receiver
		out_word_t got;
		seq_result_s want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got = out_word_t'(m_axis_tdata);
				if (owed_results.size() == 0) begin
					$display("%0t ns: result word with nothing expected, got data %h action %0d",
						$time, m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					check_field("accepted", want.accepted, got.accepted);
					check_field("seq_state", want.state, got.seq_state);
					check_field("step_index", want.idx, got.step_index);
					check_field("step_count", want.cnt, got.step_count);
					check_field("action", want.act.kind, m_axis_tuser);
					check_field("action_joint", want.act.joint, got.action_joint);
					check_field("action_dir", want.act.dir, got.action_dir);
					check_field("action_speed", want.act.speed, got.action_speed);
					check_field("action_target", want.act.target, got.action_target);
					check_field("last", want.last, m_axis_tlast);
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (hold_arm && !hold_done) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= $urandom_range(0, 99) >= stall_pct;
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("run stopped after %0d cycles with %0d results outstanding",
			cycles, owed_results.size());
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] t0;
		logic [11:0] set_min[NUM_SETS];
		logic [11:0] set_max[NUM_SETS];
		set_min = '{12'd0, 12'd3600, 12'd1, 12'd2000, 12'd1};
		set_max = '{12'd4095, 12'd3600, 12'd1, 12'd100, 12'd3600};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		t0 = ms_now;
		put(CMD_TICK, '0, '0, '0, '0, t0, FL_NORMAL);
		put(CMD_RUN, '0, '0, '0, '0, t0, FL_NORMAL);
		put(CMD_ADD_TIMED, JOINT_GRIPPER, DIR_OPEN, 8'd0, 32'd5, t0, FL_NORMAL);
		put(CMD_ADD_TIMED, JOINT_GRIPPER, DIR_OPEN, 8'd101, 32'd5, t0, FL_NORMAL);
		put(CMD_ADD_TIMED, JOINT_GRIPPER, DIR_OPEN, 8'd255, 32'd5, t0, FL_NORMAL);
		put(CMD_ADD_TIMED, JOINT_GRIPPER, DIR_OPEN, 8'd1, 32'd0, t0, FL_NORMAL);
		put(CMD_ADD_ANGLE, JOINT_BASE, DIR_UP, 8'd50, 32'd100, t0, FL_NORMAL);
		put(CMD_ADD_ANGLE, JOINT_BASE, DIR_LEFT, 8'd50, 32'd3601, t0, FL_NORMAL);
		put(CMD_ADD_TIMED, JOINT_GRIPPER, DIR_OPEN, 8'd1, 32'd5, t0, FL_NORMAL);
		put(CMD_ADD_ANGLE, JOINT_GRIPPER, DIR_LEFT, 8'd100, 32'd3600, t0, FL_NORMAL);
		put(CMD_ADD_ANGLE, JOINT_BASE, DIR_RIGHT, 8'd50, 32'd1, t0, FL_NORMAL);
		put(CMD_ADD_TIMED, JOINT_SHOULDER, DIR_UP, 8'd100, 32'hFFFF_FFFF, t0, FL_NORMAL);
		put(CMD_RUN, '0, '0, '0, '0, t0, FL_NORMAL | FL_BLOCKED);
		put(CMD_RUN, '0, '0, '0, '0, t0, FL_UP | FL_DOWN);
		put(CMD_RUN, '0, '0, '0, '0, t0, FL_NORMAL);
		put(CMD_TICK, '0, '0, '0, '0, t0 + 32'd4, FL_NORMAL);
		put(CMD_TICK, '0, '0, '0, '0, t0 + 32'd5, FL_NORMAL);
		put(CMD_TICK, '0, '0, '0, '0, t0 + 32'd6, FL_NORMAL | FL_BUSY);
		put(CMD_TICK, '0, '0, '0, '0, t0 + 32'd7, FL_NORMAL | FL_REACHED);
		put(CMD_TICK, '0, '0, '0, '0, t0 + 32'd8, FL_NORMAL);
		put(CMD_ADD_TIMED, JOINT_ELBOW, DIR_OPEN, 8'd10, 32'd3, t0, FL_NORMAL);
		put(CMD_RUN, '0, '0, '0, '0, t0 + 32'd9, FL_NORMAL);
		put(CMD_CLEAR, '0, '0, '0, '0, t0 + 32'd9, FL_NORMAL);
		put(CMD_ADD_TIMED, JOINT_SHOULDER, DIR_DOWN, 8'd100, 32'd50, t0, FL_NORMAL);
		put(CMD_RUN, '0, '0, '0, '0, t0 + 32'd10, FL_NORMAL);
		put(CMD_TICK, '0, '0, '0, '0, t0 + 32'd11, FL_ARMED | FL_UP);
		put(CMD_UNUSED, '0, '0, '0, '0, t0 + 32'd11, FL_NORMAL);
		ms_now = t0 + 32'd12;

		fill_random(150);
		wait_idle();

		gap_pct = 0;
		stall_pct = 0;
		fill_random(150);
		while (cmd_backlog.size() != 0)
			@(negedge clk);
		gap_pct = 35;
		stall_pct = 35;
		wait_idle();

		for (int ph = 0; ph < NUM_SETS; ph++) begin
			write_reg(CFG_MIN_TARGET, set_min[ph]);
			write_reg(CFG_MAX_TARGET, set_max[ph]);
			if (ph == 1) begin
				write_reg(CFG_SPARE_LO, $urandom);
				write_reg(CFG_SPARE_HI, $urandom);
			end
			fill_random(180);
			if (ph == 0)
				hold_arm = 1'b1;
			wait_idle();
		end

		$display("covered %0d command words and %0d result words, %0d sequences ran to the end",
			words_in, results_seen, completions);
		$display("target limits: reset pair plus %0d written, incl. zero minimum and min above max",
			NUM_SETS);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
